// File: src/lsa_pkg.sv
`timescale 1ns / 1ps
package lsa_pkg;

	typedef enum logic [1:0] {
		MODE_WRAP     = 2'd0,
		MODE_EXPAND   = 2'd1,
		MODE_SPAN_REL = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OP_PASS = 2'd0,
		OP_EXP  = 2'd1,
		OP_REL  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_JITTER = 2'd1,
		REG_LATE   = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	localparam int unsigned TOL_BITS = 22;
	localparam logic [1:0] MODE_RESET = 2'd2;
	localparam logic [TOL_BITS-1:0] JITTER_RESET = 22'd11025;
	localparam logic [TOL_BITS-1:0] LATE_RESET = 22'd4410;

endpackage

// File: src/lsa_front.sv
`timescale 1ns / 1ps
module lsa_front import lsa_pkg::*; #(
	parameter int W = 28,
	parameter int CTX_W = 5 * 28 + 26
) (
	input  logic [W-1:0]        stop_pos,
	input  logic [W-1:0]        take_start,
	input  logic [W-1:0]        span_len,
	input  logic [W-1:0]        offs_in,
	input  logic [W-1:0]        loop_in,
	input  logic [W-1:0]        end_in,
	input  logic [1:0]          mode,
	input  logic [TOL_BITS-1:0] tol,
	input  logic [TOL_BITS-1:0] late,
	output logic [CTX_W-1:0]    ctx,
	output logic [W-1:0]        num,
	output logic [W-1:0]        den
);

	localparam int SW = ((W > TOL_BITS) ? W : TOL_BITS) + 3;

	logic signed [SW-1:0] stop_x, start_x, span_x, tol_x, late_x;
	logic signed [SW-1:0] offs_n, local_d, rel_d, rel_abs;
	logic                 span_nz, grow, neg;
	op_t                  op;
	logic [W-1:0]         offs_out;

	always_comb begin
		stop_x  = SW'(stop_pos);
		start_x = SW'(take_start);
		span_x  = SW'(span_len);
		tol_x   = SW'(tol);
		late_x  = SW'(late);
		span_nz = span_len != '0;
		offs_n  = ((span_x - start_x) < late_x) ? span_x : '0;
		local_d = stop_x - offs_n;
		rel_d   = stop_x - start_x;
		rel_abs = rel_d[SW-1] ? -rel_d : rel_d;
		grow    = 1'b0;
		neg     = 1'b0;
		num     = '0;
		offs_out = offs_in;
		op      = OP_PASS;
		if (mode == MODE_EXPAND && span_nz) begin
			op       = OP_EXP;
			grow     = local_d > (span_x + tol_x);
			num      = grow ? local_d[W-1:0] : '0;
			offs_out = offs_n[W-1:0];
		end else if (mode == MODE_SPAN_REL && span_nz) begin
			op  = OP_REL;
			neg = rel_d[SW-1];
			num = rel_abs[W-1:0];
		end
		den = span_len;
		ctx = {op, grow, neg, tol, take_start, stop_pos, offs_out, loop_in, end_in};
	end

endmodule

// File: src/lsa_div_cell.sv
`timescale 1ns / 1ps
module lsa_div_cell #(
	parameter int W = 28,
	parameter int CTX_W = 5 * 28 + 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CTX_W-1:0] in_ctx,
	input  logic [W-1:0]     in_num,
	input  logic [W-1:0]     in_rem,
	input  logic [W-1:0]     in_den,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CTX_W-1:0] out_ctx,
	output logic [W-1:0]     out_num,
	output logic [W-1:0]     out_rem,
	output logic [W-1:0]     out_den
);

	logic [W:0]   trial;
	logic         take;
	logic [W-1:0] rem_n;
	logic         valid_q;
	logic [CTX_W-1:0] ctx_q;
	logic [W-1:0] num_q, rem_q, den_q;

	always_comb begin
		trial = {in_rem, in_num[W-1]};
		take  = trial >= {1'b0, in_den};
		rem_n = take ? W'(trial - {1'b0, in_den}) : trial[W-1:0];
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctx_q <= in_ctx;
			num_q <= {in_num[W-2:0], take};
			rem_q <= rem_n;
			den_q <= in_den;
		end
	end

	assign out_valid = valid_q;
	assign out_ctx   = ctx_q;
	assign out_num   = num_q;
	assign out_rem   = rem_q;
	assign out_den   = den_q;

endmodule

// File: src/lsa_back.sv
`timescale 1ns / 1ps
module lsa_back import lsa_pkg::*; #(
	parameter int W = 28,
	parameter int CTX_W = 5 * 28 + 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CTX_W-1:0] in_ctx,
	input  logic [W-1:0]     quo,
	input  logic [W-1:0]     rem,
	input  logic [W-1:0]     span,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [W-1:0]     span_out,
	output logic [W-1:0]     offs_out,
	output logic [W-1:0]     loop_out,
	output logic [W-1:0]     end_out,
	output logic             reset_out
);

	localparam int TW = ((W > TOL_BITS) ? W : TOL_BITS) + 1;

	op_t                 op;
	logic                grow_f, neg;
	logic [TOL_BITS-1:0] tol;
	logic [W-1:0]        start, stop, offs, loop, tend;
	logic                rlt, rgt, rnz, cond, grow_n, q_ge2, q_gt1, q_eq1;
	logic [W:0]          mult_n;
	logic [W-1:0]        loop_n;

	logic         v1_q, v2_q, v3_q, rdy1, rdy2, rdy3;
	logic         grow_s1, rst_s1, grow_s2, rst_s2;
	logic [W:0]   mult_s1;
	logic [W-1:0] span_s1, stop_s1, offs_s1, loop_s1, end_s1;
	logic [W-1:0] span_s2, stop_s2, offs_s2, loop_s2, end_s2;
	logic [2*W:0] prod_s2;
	logic [W-1:0] span_f;
	logic [W-1:0] span_q, offs_q, loop_q, end_q;
	logic         rst_q;

	always_comb begin
		op     = op_t'(in_ctx[5*W+24 +: 2]);
		grow_f = in_ctx[5*W+23];
		neg    = in_ctx[5*W+22];
		tol    = in_ctx[5*W +: TOL_BITS];
		start  = in_ctx[4*W +: W];
		stop   = in_ctx[3*W +: W];
		offs   = in_ctx[2*W +: W];
		loop   = in_ctx[W +: W];
		tend   = in_ctx[0 +: W];
		rlt    = TW'(rem) < TW'(tol);
		rgt    = TW'(rem) > TW'(tol);
		rnz    = rem != '0;
		q_ge2  = quo >= W'(2);
		q_gt1  = quo > W'(1);
		q_eq1  = quo == W'(1);
		cond   = (neg && rnz) || rlt;
		grow_n = 1'b0;
		mult_n = '0;
		loop_n = loop;
		unique case (op)
			OP_EXP: begin
				grow_n = grow_f;
				mult_n = (W+1)'(quo) + (W+1)'(rgt);
			end
			OP_REL: begin
				grow_n = !neg && (cond ? q_ge2 : (q_gt1 || (q_eq1 && rnz)));
				mult_n = cond ? (W+1)'(quo) : (W+1)'(quo) + (W+1)'(rnz);
				if (grow_n) begin
					loop_n = start;
				end else if (start < span && stop < span) begin
					loop_n = '0;
				end else begin
					loop_n = start;
				end
			end
			default: begin
				grow_n = 1'b0;
			end
		endcase
	end

	assign rdy3     = !v3_q || out_ready;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
		end
	end

	always_comb begin
		if (grow_s2) begin
			span_f = (prod_s2 > (2*W+1)'({W{1'b1}})) ? {W{1'b1}} : prod_s2[W-1:0];
		end else if (rst_s2) begin
			span_f = stop_s2;
		end else begin
			span_f = span_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			grow_s1 <= grow_n;
			rst_s1  <= (op == OP_PASS) && (span == '0);
			mult_s1 <= mult_n;
			span_s1 <= span;
			stop_s1 <= stop;
			offs_s1 <= offs;
			loop_s1 <= loop_n;
			end_s1  <= tend;
		end
		if (rdy2 && v1_q) begin
			prod_s2 <= (2*W+1)'(span_s1) * (2*W+1)'(mult_s1);
			grow_s2 <= grow_s1;
			rst_s2  <= rst_s1;
			span_s2 <= span_s1;
			stop_s2 <= stop_s1;
			offs_s2 <= offs_s1;
			loop_s2 <= loop_s1;
			end_s2  <= end_s1;
		end
		if (rdy3 && v2_q) begin
			span_q <= span_f;
			offs_q <= offs_s2;
			loop_q <= loop_s2;
			end_q  <= (end_s2 != '0) ? end_s2 : span_f;
			rst_q  <= rst_s2;
		end
	end

	assign out_valid = v3_q;
	assign span_out  = span_q;
	assign offs_out  = offs_q;
	assign loop_out  = loop_q;
	assign end_out   = end_q;
	assign reset_out = rst_q;

endmodule

// File: src/loop_span_aligner.sv
`timescale 1ns / 1ps
// loop span aligner: one request per closed take, one result per request
// s_* channel: a take (stop, start, span, offset, loop point, end), taken
//   when s_tvalid and s_tready are both high
// m_* channel: new span, offset, loop point and end in m_tdata, position
//   reset flag in m_tuser
// cfg_* channel: register writes (0 mode, 1 jitter tolerance, 2 late start
//   window), always ready, index 3 is ignored; write only while idle
// throughput: one request per cycle while m_tready stays high; the quotient
//   comes from a row of POS_BITS restoring divide cells, one quotient bit per
//   cell, followed by a decode stage, a multiply stage and a saturate stage
// every stage has its own valid bit and accepts while it is empty or the next
// stage moves, so a stalled receiver fills the pipe before s_tready drops
// reset empties the pipe and restores mode 2, tolerance 11025, window 4410
module loop_span_aligner import lsa_pkg::*; #(
	parameter int POS_BITS = 28
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// stop_pos, take_start, span_len, track_offset_in, track_loop_in, track_end_in
	input  logic [((6*POS_BITS+7)/8)*8-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// span_len_out, track_offset_out, track_loop_out, track_end_out
	output logic [((4*POS_BITS+7)/8)*8-1:0]      m_tdata,
	// pos_reset
	output logic                                 m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [TOL_BITS-1:0]                  cfg_data
);

	localparam int W = POS_BITS;
	localparam int CTX_W = 5 * W + 26;
	localparam int OUT_W = ((4*POS_BITS+7)/8)*8;

	logic [1:0]          mode_q;
	logic [TOL_BITS-1:0] jitter_q, late_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RESET;
			jitter_q <= JITTER_RESET;
			late_q   <= LATE_RESET;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_JITTER: jitter_q <= cfg_data;
				REG_LATE:   late_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	logic             vld [W+1];
	logic             rdy [W+1];
	logic [CTX_W-1:0] ctx [W+1];
	logic [W-1:0]     num [W+1];
	logic [W-1:0]     rem [W+1];
	logic [W-1:0]     den [W+1];

	lsa_front #(.W(W), .CTX_W(CTX_W)) u_front (
		.stop_pos   (s_tdata[0 +: W]),
		.take_start (s_tdata[W +: W]),
		.span_len   (s_tdata[2*W +: W]),
		.offs_in    (s_tdata[3*W +: W]),
		.loop_in    (s_tdata[4*W +: W]),
		.end_in     (s_tdata[5*W +: W]),
		.mode       (mode_q),
		.tol        (jitter_q),
		.late       (late_q),
		.ctx        (ctx[0]),
		.num        (num[0]),
		.den        (den[0])
	);

	assign vld[0]   = s_tvalid;
	assign rem[0]   = '0;
	assign s_tready = rdy[0];

	for (genvar i = 0; i < W; i++) begin : g_cell
		lsa_div_cell #(.W(W), .CTX_W(CTX_W)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_ctx    (ctx[i]),
			.in_num    (num[i]),
			.in_rem    (rem[i]),
			.in_den    (den[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_ctx   (ctx[i+1]),
			.out_num   (num[i+1]),
			.out_rem   (rem[i+1]),
			.out_den   (den[i+1])
		);
	end

	logic [W-1:0] span_o, offs_o, loop_o, end_o;

	lsa_back #(.W(W), .CTX_W(CTX_W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[W]),
		.in_ready  (rdy[W]),
		.in_ctx    (ctx[W]),
		.quo       (num[W]),
		.rem       (rem[W]),
		.span      (den[W]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.span_out  (span_o),
		.offs_out  (offs_o),
		.loop_out  (loop_o),
		.end_out   (end_o),
		.reset_out (m_tuser)
	);

	assign m_tdata = OUT_W'({end_o, loop_o, offs_o, span_o});

`ifndef SYNTHESIS
	a_span_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> span_o != '0)
		else $error("span zero without position reset");
	a_end_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (end_o != '0) || (span_o == '0))
		else $error("track end left unset");
	a_mode_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == REG_MODE |=> mode_q == $past(cfg_data[1:0]))
		else $error("mode write lost");
	a_jit_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == REG_JITTER |=> jitter_q == $past(cfg_data))
		else $error("tolerance write lost");
`endif

endmodule

// File: bench/tb_loop_span_aligner.sv
`timescale 1ns / 1ps
module tb_loop_span_aligner;
	import lsa_pkg::*;

	localparam int PB = 28;
	localparam int IW = ((6*PB+7)/8)*8;
	localparam int OW = ((4*PB+7)/8)*8;
	localparam int LAT = PB + 3;
	localparam longint PMAX = (64'd1 << PB) - 1;

	typedef struct packed {
		logic [PB-1:0] span;
		logic [PB-1:0] offs;
		logic [PB-1:0] loop_pt;
		logic [PB-1:0] tend;
		logic          rst_flag;
	} take_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OW-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [TOL_BITS-1:0] cfg_data = '0;

	mode_t cur_mode;
	longint cur_jitter, cur_late;
	take_res_t aligned_q[$];
	int errors = 0;
	int burst_left = 0;
	bit hold_off = 0;
	bit stall_random = 1;

	always #5 clk = ~clk;

	loop_span_aligner #(.POS_BITS(PB)) u_dut (.*);

	function automatic longint sat_span(longint v);
		if (v < 0) return 0;
		if (v > PMAX) return PMAX;
		return v;
	endfunction

	function automatic take_res_t align_take(longint stop, longint start, longint span,
			longint offs, longint loop_pt, longint tend);
		take_res_t r;
		longint rel, mult, lcl;
		r.rst_flag = 0;
		if (cur_mode == MODE_EXPAND && span != 0) begin
			offs = (span - start < cur_late) ? span : 0;
			if (stop - offs > span + cur_jitter) begin
				lcl = stop - offs;
				mult = lcl / span;
				if (lcl - span * mult > cur_jitter) mult++;
				span = sat_span(span * mult);
			end
		end else if (cur_mode == MODE_SPAN_REL && span != 0) begin
			rel = stop - start;
			if (rel % span < cur_jitter) begin
				rel = (rel / span) * span;
				if (rel == 0) rel = span;
			end
			if (rel > span) begin
				mult = rel / span + ((rel % span) != 0 ? 1 : 0);
				span = sat_span(mult * span);
				loop_pt = start;
			end else if (start < span && stop < span) begin
				loop_pt = 0;
			end else begin
				loop_pt = start;
			end
		end
		if (span == 0) begin
			span = stop;
			r.rst_flag = 1;
		end
		if (tend == 0) tend = span;
		r.span = span[PB-1:0];
		r.offs = offs[PB-1:0];
		r.loop_pt = loop_pt[PB-1:0];
		r.tend = tend[PB-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic send_take(longint stop, longint start, longint span, longint offs,
			longint loop_pt, longint tend);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tdata <= {tend[PB-1:0], loop_pt[PB-1:0], offs[PB-1:0], span[PB-1:0],
			start[PB-1:0], stop[PB-1:0]};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		aligned_q.insert(aligned_q.size(), align_take(stop, start, span, offs, loop_pt, tend));
		burst_left--;
	endtask

	task automatic finish_sending();
		s_tvalid <= 0;
		burst_left = 0;
	endtask

	task automatic drain();
		finish_sending();
		while (aligned_q.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, longint val);
		cfg_index <= idx;
		cfg_data <= val[TOL_BITS-1:0];
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
		case (idx)
			REG_MODE: cur_mode = mode_t'(val[1:0]);
			REG_JITTER: cur_jitter = val & 64'h3FFFFF;
			REG_LATE: cur_late = val & 64'h3FFFFF;
			default: ;
		endcase
	endtask

	function automatic longint rpos();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return PMAX;
			2: return $urandom_range(0, 100000);
			default: return $urandom & PMAX;
		endcase
	endfunction

	task automatic random_take();
		longint span, start, stop, k;
		span = ($urandom_range(0, 9) == 0) ? 0 :
			($urandom_range(0, 3) == 0 ? rpos() : $urandom_range(1, 200000));
		if ($urandom_range(0, 4) == 0 || span == 0) begin
			start = rpos();
			stop = rpos();
		end else begin
			start = $urandom_range(0, 3) == 0 ? span - $urandom_range(0, 8000) :
				$urandom_range(0, 3 * span);
			k = $urandom_range(0, 5);
			stop = start + k * span + $urandom_range(0, 30000) - 15000;
			if (start < 0) start = 0;
			if (stop < 0) stop = 0;
			if (start > PMAX) start = PMAX;
			if (stop > PMAX) stop = PMAX;
		end
		send_take(stop, start, span, rpos(), rpos(),
			$urandom_range(0, 2) == 0 ? 0 : rpos());
	endtask

	task automatic test_directed();
		send_take(0, 0, 0, 0, 0, 0);
		send_take(PMAX, PMAX, 0, PMAX, PMAX, PMAX);
		send_take(44100, 0, 44100, 5, 6, 0);
		send_take(44100 + 100, 0, 44100, 5, 6, 7);
		send_take(3 * 44100 + 20000, 0, 44100, 0, 0, 0);
		send_take(1000, 5000, 44100, 1, 2, 0);
		send_take(PMAX, 0, 3, 0, 0, 0);
		send_take(PMAX, 0, PMAX, 0, 0, 0);
		send_take(50000, 42000, 44100, 9, 9, 0);
		send_take(200000, 43000, 44100, 0, 0, 0);
		drain();
		write_reg(REG_MODE, MODE_EXPAND);
		send_take(44100 + 100, 0, 44100, 7, 7, 0);
		send_take(4 * 44100, 41000, 44100, 7, 7, 0);
		send_take(PMAX, 0, 5, 0, 0, 0);
		send_take(10, 0, 0, 3, 3, 0);
		send_take(100, 200000, 44100, 0, 0, 0);
		drain();
		write_reg(REG_MODE, MODE_WRAP);
		send_take(1234, 55, 44100, 1, 2, 0);
		send_take(1234, 55, 0, 1, 2, 3);
		drain();
		write_reg(REG_MODE, MODE_UNUSED);
		send_take(999, 55, 44100, 8, 9, 0);
		drain();
	endtask

	task automatic test_random_phases();
		longint tols[4] = '{0, 4194303, 11025, 100};
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_MODE, ph % 4);
			write_reg(REG_JITTER, ph < 4 ? tols[ph] : $urandom_range(0, 40000));
			write_reg(REG_LATE, ph == 1 ? 4194303 : ph == 2 ? 0 : $urandom_range(0, 20000));
			repeat (ph % 4 == 3 ? 60 : 160) random_take();
			drain();
		end
	endtask

	task automatic test_backpressure();
		write_reg(REG_MODE, MODE_SPAN_REL);
		hold_off = 1;
		fork
			begin
				repeat (3 * LAT) @(posedge clk);
				hold_off = 0;
			end
			repeat (3 * LAT) random_take();
		join
		finish_sending();
		while (aligned_q.size() != 0) @(posedge clk);
		stall_random = 0;
		repeat (200) random_take();
		drain();
		stall_random = 1;
	endtask

	always @(posedge clk) begin
		m_tready <= !hold_off && (!stall_random || ($urandom_range(0, 7) != 0));
	end

	always @(posedge clk) begin
		take_res_t w;
		if (m_tvalid && m_tready) begin
			if (aligned_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				w = aligned_q.pop_front();
				if (m_tdata[PB-1:0] !== w.span)
					report_mismatch("span_len_out", m_tdata[PB-1:0], w.span);
				if (m_tdata[2*PB-1:PB] !== w.offs)
					report_mismatch("track_offset_out", m_tdata[2*PB-1:PB], w.offs);
				if (m_tdata[3*PB-1:2*PB] !== w.loop_pt)
					report_mismatch("track_loop_out", m_tdata[3*PB-1:2*PB], w.loop_pt);
				if (m_tdata[4*PB-1:3*PB] !== w.tend)
					report_mismatch("track_end_out", m_tdata[4*PB-1:3*PB], w.tend);
				if (m_tuser !== w.rst_flag)
					report_mismatch("pos_reset", m_tuser, w.rst_flag);
			end
		end
	end

	initial begin
		#20ms;
		$display("loop_span_aligner test failed");
		$finish;
	end

	initial begin
		cur_mode = MODE_SPAN_REL;
		cur_jitter = 11025;
		cur_late = 4410;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random_phases();
		test_backpressure();
		if (errors == 0 && aligned_q.size() == 0) begin
			$display("loop_span_aligner test passed");
		end else begin
			$display("loop_span_aligner test failed");
		end
		$finish;
	end
endmodule

// File: sim.f
src/lsa_pkg.sv
src/lsa_front.sv
src/lsa_div_cell.sv
src/lsa_back.sv
src/loop_span_aligner.sv
bench/tb_loop_span_aligner.sv
